FILE: sv/ale_pkg.sv
// Shared constants, command and status codes, and cell control type for the list engine.
package ale_pkg;

  localparam int KIND_W      = 3;
  localparam int POS_W       = 7;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 3;
  localparam int FIDX_W      = 6;
  localparam int COUNT_W     = 7;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INSERT_AT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UPDATE     = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd7;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  // Broadcast to every cell; at most one flag is high in a cycle.
  typedef struct packed {
    logic insert;
    logic remove;
    logic update;
  } cell_ctrl_t;

endpackage

FILE: sv/ale_cmd_if.sv
// Command channel: valid/ready handshake carrying one list command.
interface ale_cmd_if import ale_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [POS_W-1:0]          position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

FILE: sv/ale_rsp_if.sv
// Response channel: valid/ready handshake carrying one command result.
interface ale_rsp_if import ale_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] value_out;
  logic [FIDX_W-1:0]         found_index;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, status, value_out, found_index, count, input ready);
  modport sink   (input valid, status, value_out, found_index, count, output ready);
endinterface

FILE: sv/ale_cell.sv
// One list element cell: holds a word, shifts with its neighbors and compares against the key.
module ale_cell import ale_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [IDX_W-1:0]      k,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] din,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  match
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MyCnt = CNT_W'(INDEX);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (MyIdx > k) begin
        data <= left;
      end else if (MyIdx == k) begin
        data <= din;
      end
    end else if (ctrl.remove) begin
      if (MyIdx >= k) begin
        data <= right;
      end
    end else if (ctrl.update) begin
      if (MyIdx == k) begin
        data <= din;
      end
    end
  end

  // Only occupied cells may report a hit.
  assign match = (data == din) && (MyCnt < count);

endmodule

FILE: sv/ale_find_tree.sv
// Registered priority tree that turns the cell hit vector into the lowest matching index.
module ale_find_tree import ale_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [DEPTH-1:0]         hits,
  output logic                     out_valid,
  output logic                     found,
  output logic [$clog2(DEPTH)-1:0] index
);

  localparam int Levels = $clog2(DEPTH);
  localparam int Leaves = 1 << Levels;

  logic [Leaves-1:0] hits_pad;
  logic              node_hit [1:2*Leaves-1];
  logic [Levels-1:0] node_idx [1:Leaves-1];
  logic [Levels:0]   vpipe;

  assign hits_pad = Leaves'(hits);

  // Heap layout: node n has children 2n and 2n+1, leaves sit at Leaves..2*Leaves-1.
  always_ff @(posedge clk) begin
    for (int j = 0; j < Leaves; j++) begin
      node_hit[Leaves + j] <= hits_pad[j];
    end
    for (int n = 1; n < Leaves; n++) begin
      node_hit[n] <= node_hit[2*n] | node_hit[2*n+1];
      if (2*n >= Leaves) begin
        node_idx[n] <= node_hit[2*n] ? Levels'(2*n - Leaves) : Levels'(2*n + 1 - Leaves);
      end else begin
        node_idx[n] <= node_hit[2*n] ? node_idx[2*n] : node_idx[2*n+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[Levels-1:0], in_valid};
    end
  end

  assign out_valid = vpipe[Levels];
  assign found     = node_hit[1];
  assign index     = node_idx[1];

endmodule

FILE: sv/array_list_engine.sv
// Ordered list engine: a row of element cells with push, pop, insert, remove, update and search.
// Every command except search gives its result in the cycle after its transfer; a search result
// passes the registered priority tree, then the result register. Throughput: one command per
// cycle for non-search commands when the response side is ready; a search blocks new commands
// until its result is out. Reset (rst, synchronous) empties the list and drops any result.
module array_list_engine import ale_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  ale_cmd_if.sink   cmd,
  ale_rsp_if.source rsp
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // Width for position and count arithmetic, one bit above the wider of the two.
  localparam int PW     = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  // Common width for moving the value between the port and the stored word.
  localparam int WIDE_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  // The element count is the only control state of the list itself.
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic busy;          // a search is walking through the tree
  logic accept;

  // Result register that decouples the response side.
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_value;
  logic [FIDX_W-1:0]   out_fidx;
  logic [COUNT_W-1:0]  out_count;

  // Decoded command.
  cell_ctrl_t          ctrl;
  cell_ctrl_t          ctrl_gated;
  logic [IDX_W-1:0]    k_idx;
  logic [STATUS_W-1:0] dec_status;
  logic                take;
  logic                is_search;

  logic [DATA_WIDTH-1:0] data_in;
  logic [WIDE_W-1:0]     value_wide;
  logic [WIDE_W-1:0]     read_wide;
  logic [DATA_WIDTH-1:0] read_data;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [PW-1:0] pos_m1;
  logic [PW-1:0] cnt_m1;
  logic          full;
  logic          empty;
  logic          pos_ok;
  logic          pos_ins_ok;

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic [DATA_WIDTH-1:0] left_data  [DEPTH];
  logic [DATA_WIDTH-1:0] right_data [DEPTH];
  logic [DEPTH-1:0]      hits;

  logic                    tree_valid;
  logic                    tree_found;
  logic [IDX_W-1:0]        tree_index;
  logic [IDX_W+FIDX_W-1:0] tree_index_wide;
  logic [CNT_W+COUNT_W-1:0] cnt_next_wide;
  logic [CNT_W+COUNT_W-1:0] cnt_wide;

  // A new command is taken when no search is pending and the result slot is free or
  // is being emptied in this same cycle.
  assign cmd.ready = !busy && (!out_valid || rsp.ready);
  assign accept    = cmd.valid && cmd.ready;

  // The stored word keeps the low DATA_WIDTH bits of the value; narrower words zero-extend
  // on the way out.
  assign value_wide = WIDE_W'($unsigned(cmd.value));
  assign data_in    = value_wide[DATA_WIDTH-1:0];

  assign pos_w      = PW'(cmd.position);
  assign cnt_w      = PW'(cnt);
  assign pos_m1     = pos_w - PW'(1);
  assign cnt_m1     = cnt_w - PW'(1);
  assign full       = (cnt == FullCnt);
  assign empty      = (cnt == '0);
  assign pos_ok     = (pos_w != '0) && (pos_w <= cnt_w);
  assign pos_ins_ok = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign is_search  = (cmd.kind == KIND_SEARCH);

  // Command decode. Every error leaves the cells and the count as they are.
  always_comb begin
    ctrl       = '0;
    k_idx      = '0;
    dec_status = ST_OK;
    take       = 1'b0;
    cnt_next   = cnt;
    case (cmd.kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          ctrl.insert = 1'b1;
          cnt_next    = cnt + CNT_W'(1);
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          dec_status = ST_FULL;
        end else begin
          ctrl.insert = 1'b1;
          k_idx       = cnt[IDX_W-1:0];
          cnt_next    = cnt + CNT_W'(1);
        end
      end
      KIND_INSERT_AT: begin
        // The position check wins over the full check.
        if (!pos_ins_ok) begin
          dec_status = ST_BADPOS;
        end else if (full) begin
          dec_status = ST_FULL;
        end else begin
          ctrl.insert = 1'b1;
          k_idx       = pos_m1[IDX_W-1:0];
          cnt_next    = cnt + CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          ctrl.remove = 1'b1;
          take        = 1'b1;
          cnt_next    = cnt - CNT_W'(1);
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          dec_status = ST_EMPTY;
        end else begin
          ctrl.remove = 1'b1;
          take        = 1'b1;
          k_idx       = cnt_m1[IDX_W-1:0];
          cnt_next    = cnt - CNT_W'(1);
        end
      end
      KIND_REMOVE_AT: begin
        if (!pos_ok) begin
          dec_status = ST_BADPOS;
        end else begin
          ctrl.remove = 1'b1;
          take        = 1'b1;
          k_idx       = pos_m1[IDX_W-1:0];
          cnt_next    = cnt - CNT_W'(1);
        end
      end
      KIND_UPDATE: begin
        if (!pos_ok) begin
          dec_status = ST_BADPOS;
        end else begin
          ctrl.update = 1'b1;
          k_idx       = pos_m1[IDX_W-1:0];
        end
      end
      default: begin
        // Search: the cells compare in parallel and the tree picks the first hit.
        dec_status = ST_NOTFOUND;
      end
    endcase
  end

  // The cells only move on a transfer.
  assign ctrl_gated = accept ? ctrl : '0;

  // The element leaving the list is read out before the row shifts over it.
  assign read_data = cell_data[k_idx];
  assign read_wide = WIDE_W'(read_data);

  // Row of cells. Each cell sees its left and right neighbor; the ends take the new word and
  // their own content.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cells
    if (i == 0) begin : g_first
      assign left_data[i] = data_in;
    end else begin : g_left
      assign left_data[i] = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data[i] = cell_data[i];
    end else begin : g_right
      assign right_data[i] = cell_data[i+1];
    end

    ale_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .INDEX      (i)
    ) u_cell (
      .clk   (clk),
      .ctrl  (ctrl_gated),
      .k     (k_idx),
      .count (cnt),
      .din   (data_in),
      .left  (left_data[i]),
      .right (right_data[i]),
      .data  (cell_data[i]),
      .match (hits[i])
    );
  end

  // The hit vector is captured at the transfer of a search, so the tree sees the list as the
  // command found it; the list cannot change while the search is pending.
  ale_find_tree #(
    .DEPTH (DEPTH)
  ) u_find (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && is_search),
    .hits      (hits),
    .out_valid (tree_valid),
    .found     (tree_found),
    .index     (tree_index)
  );

  // Port fields are the low bits of the internal index and count.
  assign tree_index_wide = (IDX_W + FIDX_W)'(tree_index);
  assign cnt_next_wide   = (CNT_W + COUNT_W)'(cnt_next);
  // A search leaves the count alone, and the command waiting at the input while the tree
  // works must not leak into its result.
  assign cnt_wide        = (CNT_W + COUNT_W)'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept && !is_search) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (tree_valid) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept && is_search) begin
        busy <= 1'b1;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept && !is_search) begin
      out_status <= dec_status;
      out_value  <= take ? read_wide[VALUE_W-1:0] : '0;
      out_fidx   <= '0;
      out_count  <= cnt_next_wide[COUNT_W-1:0];
    end else if (tree_valid) begin
      out_status <= tree_found ? ST_OK : ST_NOTFOUND;
      out_value  <= '0;
      out_fidx   <= tree_found ? tree_index_wide[FIDX_W-1:0] : '0;
      out_count  <= cnt_wide[COUNT_W-1:0];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.value_out   = $signed(out_value);
  assign rsp.found_index = out_fidx;
  assign rsp.count       = out_count;

endmodule

FILE: sim/array_list_engine_tb.sv
// Self-checking testbench for the ordered list engine: directed table, random traffic, predictor.
`timescale 1ns / 1ps

module array_list_engine_tb;
  import ale_pkg::*;

  // The list geometry matches the defaults of the block.
  localparam int LIST_DEPTH    = DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 500;
  // The calm tail at the end of the random part has no idling on either side.
  localparam int CALM_TAIL     = 80;
  // A search is the slowest command, and this wait outlasts it to catch a stray result after
  // the last expected one.
  localparam int SETTLE_CYCLES = 16;
  localparam int TIMEOUT_NS    = 1_000_000;
  localparam int MAX_PRINTED   = 40;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value_out;
    logic [FIDX_W-1:0]         found_index;
    logic [COUNT_W-1:0]        count;
  } list_result_t;

  // One row of the directed table. Rows with a typed result carry the answer that can be
  // read straight off the command; the others are checked against the predictor.
  typedef struct {
    list_cmd_t    cmd;
    bit           typed;
    list_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ale_cmd_if cmd_bus ();
  ale_rsp_if rsp_bus ();

  array_list_engine #(
    .DEPTH      (LIST_DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  always #4 clk = ~clk;

  // Predictor state: the list contents and the number of valid entries.
  logic signed [VALUE_W-1:0] list_elems [LIST_DEPTH];
  int                        list_count;

  // Results the block still owes, oldest first.
  list_result_t  pending_results [$];
  directed_row_t directed_rows [$];

  int error_count     = 0;
  int results_checked = 0;
  int commands_sent   = 0;
  int directed_sent   = 0;
  int peak_count      = 0;
  int status_tally [5];

  // Traffic shaping. The random part sweeps the list between empty and full so that the
  // full and empty cases are hit repeatedly instead of hovering around a middle size.
  bit filling     = 1'b1;
  int bound_hits  = 0;
  bit quiet       = 1'b0;
  bit sender_calm = 1'b0;
  bit recv_calm   = 1'b0;

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] ERROR: %s", $time, what);
    end
  endtask

  // Applies one command to the predicted list and returns the result the block must give.
  // Every error leaves the list alone and reports the current size.
  function automatic list_result_t apply_list_command(input list_cmd_t c);
    list_result_t r;
    int           i;
    int           slot;
    r        = '0;
    r.status = ST_OK;
    case (c.kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT_AT: begin
        if (c.kind == KIND_PUSH_FRONT) begin
          slot = 0;
        end else if (c.kind == KIND_PUSH_BACK) begin
          slot = list_count;
        end else begin
          slot = int'(c.position) - 1;
        end
        // For an insert, the position check wins over the full check.
        if (c.kind == KIND_INSERT_AT && (c.position == 0 || c.position > list_count + 1)) begin
          r.status = ST_BADPOS;
        end else if (list_count >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_count; i > slot; i--) begin
            list_elems[i] = list_elems[i-1];
          end
          list_elems[slot] = c.value;
          list_count++;
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK, KIND_REMOVE_AT: begin
        if (c.kind == KIND_POP_FRONT) begin
          slot = 0;
        end else if (c.kind == KIND_POP_BACK) begin
          slot = list_count - 1;
        end else begin
          slot = int'(c.position) - 1;
        end
        // A remove on an empty list is a position error, never an empty error.
        if (c.kind == KIND_REMOVE_AT && (c.position == 0 || c.position > list_count)) begin
          r.status = ST_BADPOS;
        end else if (list_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value_out = list_elems[slot];
          for (i = slot; i + 1 < list_count; i++) begin
            list_elems[i] = list_elems[i+1];
          end
          list_count--;
        end
      end
      KIND_UPDATE: begin
        if (c.position == 0 || c.position > list_count) begin
          r.status = ST_BADPOS;
        end else begin
          list_elems[int'(c.position) - 1] = c.value;
        end
      end
      default: begin
        // Search reports the first match from the front.
        r.status = ST_NOTFOUND;
        for (i = 0; i < list_count && r.status != ST_OK; i++) begin
          if (list_elems[i] == c.value) begin
            r.status      = ST_OK;
            r.found_index = i[FIDX_W-1:0];
          end
        end
      end
    endcase
    r.count = list_count[COUNT_W-1:0];
    return r;
  endfunction

  // Draws one random command. Most commands move the list toward the current sweep target;
  // a small share is unconstrained noise over the full field ranges.
  function automatic list_cmd_t pick_random_command();
    list_cmd_t   c;
    int unsigned roll;
    int          n;
    roll       = $urandom_range(0, 99);
    n          = list_count;
    c.kind     = KIND_SEARCH;
    c.position = '0;
    // Small values make duplicates likely, which exercises first-match search.
    if ($urandom_range(0, 3) == 0) begin
      c.value = $urandom_range(0, 7);
    end else begin
      c.value = $urandom;
    end
    if (roll < 8) begin
      c.kind     = KIND_W'($urandom_range(KIND_PUSH_FRONT, KIND_SEARCH));
      c.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    end else if (roll < 16) begin
      c.kind = KIND_SEARCH;
      if (n > 0 && roll < 13) begin
        c.value = list_elems[$urandom_range(0, n - 1)];
      end
    end else if (roll < 24) begin
      c.kind     = KIND_UPDATE;
      c.position = POS_W'($urandom_range(1, (n > 0) ? n : 1));
    end else if (($urandom_range(0, 99) < 80) == filling) begin
      case ($urandom_range(0, 2))
        0:       c.kind = KIND_PUSH_FRONT;
        1:       c.kind = KIND_PUSH_BACK;
        default: begin
          c.kind     = KIND_INSERT_AT;
          c.position = POS_W'($urandom_range(1, n + 1) +
                              (($urandom_range(0, 7) == 0) ? n + 1 : 0));
        end
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       c.kind = KIND_POP_FRONT;
        1:       c.kind = KIND_POP_BACK;
        default: begin
          c.kind = KIND_REMOVE_AT;
          if ($urandom_range(0, 7) == 0) begin
            c.position = POS_W'(n + 1);
          end else begin
            c.position = POS_W'($urandom_range(1, (n > 0) ? n : 1));
          end
        end
      endcase
    end
    return c;
  endfunction

  task automatic add_directed(input logic [KIND_W-1:0] kind, input int pos,
                              input logic [VALUE_W-1:0] value, input bit typed,
                              input logic [STATUS_W-1:0] status, input logic [VALUE_W-1:0] vout,
                              input int fidx, input int cnt);
    directed_row_t r;
    r.cmd.kind         = kind;
    r.cmd.position     = pos[POS_W-1:0];
    r.cmd.value        = value;
    r.typed            = typed;
    r.want.status      = status;
    r.want.value_out   = vout;
    r.want.found_index = fidx[FIDX_W-1:0];
    r.want.count       = cnt[COUNT_W-1:0];
    directed_rows = {directed_rows, r};
  endtask

  // Presents one command and holds it until the transfer. The predictor is advanced at the
  // transfer edge, so it always reflects exactly the commands the block has taken.
  task automatic send_command(input list_cmd_t c, input bit typed, input list_result_t typed_want);
    list_result_t predicted;
    cmd_bus.valid    <= 1'b1;
    cmd_bus.kind     <= c.kind;
    cmd_bus.position <= c.position;
    cmd_bus.value    <= c.value;
    @(posedge clk);
    while (cmd_bus.ready !== 1'b1) @(posedge clk);
    predicted = apply_list_command(c);
    if (typed) begin
      pending_results = {pending_results, typed_want};
    end else begin
      pending_results = {pending_results, predicted};
    end
    commands_sent++;
    status_tally[predicted.status]++;
    if (list_count > peak_count) peak_count = list_count;
    // Flip the sweep after lingering at full or at empty for a few commands.
    if (filling && list_count == LIST_DEPTH) begin
      bound_hits++;
      if (bound_hits > 6) begin
        filling    = 1'b0;
        bound_hits = 0;
      end
    end else if (!filling && list_count == 0) begin
      bound_hits++;
      if (bound_hits > 3) begin
        filling    = 1'b1;
        bound_hits = 0;
      end
    end
  endtask

  // Sender idling: occasional bursts of empty cycles, with calm stretches between.
  task automatic maybe_pause();
    if ($urandom_range(0, 31) == 0) sender_calm = !sender_calm;
    if (!quiet && !sender_calm && $urandom_range(0, 3) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Holds off the sender until the block has returned every outstanding result.
  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver idling: ready drops in bursts, except in calm stretches and in the closing part of
  // the run.
  initial begin
    int stall_left;
    stall_left    = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 127) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (!quiet && !recv_calm && $urandom_range(0, 4) == 0) begin
        stall_left    = $urandom_range(0, 8);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Result checker: every transfer on the response channel is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst) begin
      if ($isunknown(rsp_bus.valid)) begin
        report_mismatch("response valid is unknown");
      end else if (rsp_bus.valid && rsp_bus.ready) begin
        got.status      = rsp_bus.status;
        got.value_out   = rsp_bus.value_out;
        got.found_index = rsp_bus.found_index;
        got.count       = rsp_bus.count;
        if (pending_results.size() == 0) begin
          report_mismatch("response arrived with no command outstanding");
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          results_checked++;
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d, want %0d", got.status, want.status));
          if (got.value_out !== want.value_out)
            report_mismatch($sformatf("value_out got %h, want %h",
                                      got.value_out, want.value_out));
          if (got.found_index !== want.found_index)
            report_mismatch($sformatf("found_index got %0d, want %0d",
                                      got.found_index, want.found_index));
          if (got.count !== want.count)
            report_mismatch($sformatf("count got %0d, want %0d", got.count, want.count));
        end
      end
    end
  end

  // Stimulus: reset, the directed table, then random traffic.
  initial begin
    int idx;
    cmd_bus.valid    <= 1'b0;
    cmd_bus.kind     <= KIND_PUSH_FRONT;
    cmd_bus.position <= '0;
    cmd_bus.value    <= '0;
    list_count = 0;
    foreach (status_tally[i]) status_tally[i] = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The list starts empty, so every error case on an empty list comes first. Then a few
    // elements with extreme values are built up and probed.
    add_directed(KIND_POP_FRONT,  0,   32'h0000_0000, 1, ST_EMPTY,    32'h0000_0000, 0, 0);
    add_directed(KIND_POP_BACK,   0,   32'h0000_0000, 1, ST_EMPTY,    32'h0000_0000, 0, 0);
    add_directed(KIND_REMOVE_AT,  1,   32'h0000_0000, 1, ST_BADPOS,   32'h0000_0000, 0, 0);
    add_directed(KIND_UPDATE,     1,   32'h0000_0005, 1, ST_BADPOS,   32'h0000_0000, 0, 0);
    add_directed(KIND_SEARCH,     0,   32'h0000_0000, 1, ST_NOTFOUND, 32'h0000_0000, 0, 0);
    add_directed(KIND_INSERT_AT,  0,   32'h0000_0001, 1, ST_BADPOS,   32'h0000_0000, 0, 0);
    add_directed(KIND_INSERT_AT,  2,   32'h0000_0001, 1, ST_BADPOS,   32'h0000_0000, 0, 0);
    add_directed(KIND_INSERT_AT,  1,   32'h8000_0000, 1, ST_OK,       32'h0000_0000, 0, 1);
    add_directed(KIND_PUSH_BACK,  0,   32'h7FFF_FFFF, 1, ST_OK,       32'h0000_0000, 0, 2);
    add_directed(KIND_PUSH_FRONT, 0,   32'hFFFF_FFFF, 1, ST_OK,       32'h0000_0000, 0, 3);
    // Inserting at one past the last element appends.
    add_directed(KIND_INSERT_AT,  4,   32'h0000_0000, 1, ST_OK,       32'h0000_0000, 0, 4);
    add_directed(KIND_SEARCH,     0,   32'h7FFF_FFFF, 1, ST_OK,       32'h0000_0000, 2, 4);
    add_directed(KIND_UPDATE,     4,   32'h5555_5555, 1, ST_OK,       32'h0000_0000, 0, 4);
    add_directed(KIND_REMOVE_AT,  5,   32'h0000_0000, 1, ST_BADPOS,   32'h0000_0000, 0, 4);
    add_directed(KIND_REMOVE_AT,  2,   32'h0000_0000, 1, ST_OK,       32'h8000_0000, 0, 3);
    add_directed(KIND_UPDATE,     127, 32'h0000_0000, 1, ST_BADPOS,   32'h0000_0000, 0, 3);
    add_directed(KIND_INSERT_AT,  127, 32'h0000_0000, 1, ST_BADPOS,   32'h0000_0000, 0, 3);
    add_directed(KIND_INSERT_AT,  2,   32'hAAAA_AAAA, 0, ST_OK,       32'h0000_0000, 0, 0);
    // A duplicate at the back; search must still report the one at the front.
    add_directed(KIND_PUSH_BACK,  0,   32'hFFFF_FFFF, 0, ST_OK,       32'h0000_0000, 0, 0);
    add_directed(KIND_SEARCH,     0,   32'hFFFF_FFFF, 1, ST_OK,       32'h0000_0000, 0, 5);
    add_directed(KIND_POP_BACK,   0,   32'h0000_0000, 1, ST_OK,       32'hFFFF_FFFF, 0, 4);
    add_directed(KIND_SEARCH,     0,   32'h1234_5678, 1, ST_NOTFOUND, 32'h0000_0000, 0, 4);
    add_directed(KIND_REMOVE_AT,  1,   32'h0000_0000, 0, ST_OK,       32'h0000_0000, 0, 0);
    add_directed(KIND_POP_FRONT,  0,   32'h0000_0000, 0, ST_OK,       32'h0000_0000, 0, 0);
    add_directed(KIND_SEARCH,     0,   32'h5555_5555, 0, ST_OK,       32'h0000_0000, 0, 0);

    foreach (directed_rows[i]) begin
      maybe_pause();
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    end
    directed_sent = commands_sent;

    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx == RANDOM_ITEMS - CALM_TAIL) quiet = 1'b1;
      // Twice in the run the sender waits for the block to go completely idle.
      if (idx == 150 || idx == 320) drain_results();
      maybe_pause();
      send_command(pick_random_command(), 1'b0, '0);
    end
    cmd_bus.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d commands (%0d from the table), checked %0d results, peak list size %0d.",
             commands_sent, directed_sent, results_checked, peak_count);
    $display("Status mix ok/empty/badpos/full/notfound: %0d/%0d/%0d/%0d/%0d, %0d errors.",
             status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_BADPOS],
             status_tally[ST_FULL], status_tally[ST_NOTFOUND], error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run well past any correct finish.
  initial begin
    #(TIMEOUT_NS);
    $display("[%0t] ERROR: timeout with %0d results outstanding", $time,
             pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: array_list_engine.f
sv/ale_pkg.sv
sv/ale_cmd_if.sv
sv/ale_rsp_if.sv
sv/ale_cell.sv
sv/ale_find_tree.sv
sv/array_list_engine.sv
sim/array_list_engine_tb.sv
